>>> rtl/core/phk_pkg.sv
// Shared widths, codes and status type of the packed Hermitian Kronecker product unit.
package phk_pkg;

    localparam int ORDER_W     = 3;
    localparam int CFG_INDEX_W = 1;
    localparam int LOAD_INDEX_W = 4;
    localparam int PART_W      = 24;
    localparam int ENTRY_W     = 2 * PART_W;
    localparam int PROD_W      = 49;
    localparam int OUT_INDEX_W = 8;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 112;
    localparam int IN_USER_W   = 2;

    typedef enum logic [IN_USER_W-1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_EMIT        = 2'd2
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_M_SIZE = 1'b0,
        CFG_N_SIZE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_INDEX_W-1:0] index;
        logic                   conj;
        logic                   last;
    } seq_status_t;

endpackage

>>> rtl/core/phk_store.sv
// Register file for one packed lower-triangle matrix, one write and one read port.
module phk_store
    import phk_pkg::*;
#(
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [LOAD_INDEX_W-1:0] wr_index,
    input  logic [ENTRY_W-1:0]      wr_data,
    input  logic [AW-1:0]           rd_addr,
    output logic [ENTRY_W-1:0]      rd_data
);

    // only entries that a load index can reach are kept
    localparam int STORE_DEPTH = (DEPTH < (1 << LOAD_INDEX_W)) ? DEPTH : (1 << LOAD_INDEX_W);
    localparam int SIW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [ENTRY_W-1:0] mem_reg [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en && (32'(wr_index) < STORE_DEPTH))
        begin
            mem_reg[wr_index[SIW-1:0]] <= wr_data;
        end
    end

    assign rd_data = (32'(rd_addr) < STORE_DEPTH) ? mem_reg[rd_addr[SIW-1:0]] : '0;

endmodule

>>> rtl/core/phk_seq.sv
// Order registers, position counters and packed address generation.
module phk_seq
    import phk_pkg::*;
#(
    parameter int MAX_M = 4,
    parameter int MAX_N = 4,
    localparam int DEPTH1 = MAX_M * (MAX_M + 1) / 2,
    localparam int DEPTH2 = MAX_N * (MAX_N + 1) / 2,
    localparam int AW1 = (DEPTH1 > 1) ? $clog2(DEPTH1) : 1,
    localparam int AW2 = (DEPTH2 > 1) ? $clog2(DEPTH2) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ORDER_W-1:0]     cfg_data,
    input  logic                   step,
    output logic [AW1-1:0]         a1,
    output logic [AW2-1:0]         a2,
    output seq_status_t            status
);

    localparam int RW1 = (MAX_M > 1) ? $clog2(MAX_M) : 1;
    localparam int RW2 = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int MN = MAX_M * MAX_N;
    localparam int TOTAL = MN * (MN + 1) / 2;
    localparam int CNT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    logic [RW1-1:0]   m_top_reg, m_top_next;
    logic [RW2-1:0]   n_top_reg, n_top_next;
    logic [RW1-1:0]   ro_reg, ro_next, co_reg, co_next;
    logic [RW2-1:0]   ri_reg, ri_next, ci_reg, ci_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             conj;
    logic             last;

    assign conj = ci_reg > ri_reg;
    assign last = (ro_reg == m_top_reg) && (co_reg == m_top_reg)
               && (ri_reg == n_top_reg) && (ci_reg == n_top_reg);

    assign a1 = AW1'((int'(ro_reg) * (int'(ro_reg) + 1)) / 2 + int'(co_reg));
    // above the diagonal of the second factor read the mirrored entry
    assign a2 = conj ? AW2'((int'(ci_reg) * (int'(ci_reg) + 1)) / 2 + int'(ri_reg))
                     : AW2'((int'(ri_reg) * (int'(ri_reg) + 1)) / 2 + int'(ci_reg));

    assign status.index = OUT_INDEX_W'(cnt_reg);
    assign status.conj  = conj;
    assign status.last  = last;

    always_comb
    begin
        m_top_next = m_top_reg;
        n_top_next = n_top_reg;
        ro_next    = ro_reg;
        co_next    = co_reg;
        ri_next    = ri_reg;
        ci_next    = ci_reg;
        cnt_next   = cnt_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_M_SIZE:
                begin
                    if (cfg_data == '0)
                        m_top_next = '0;
                    else if (int'(cfg_data) > MAX_M)
                        m_top_next = RW1'(MAX_M - 1);
                    else
                        m_top_next = RW1'(cfg_data - ORDER_W'(1));
                end
                CFG_N_SIZE:
                begin
                    if (cfg_data == '0)
                        n_top_next = '0;
                    else if (int'(cfg_data) > MAX_N)
                        n_top_next = RW2'(MAX_N - 1);
                    else
                        n_top_next = RW2'(cfg_data - ORDER_W'(1));
                end
                default:
                begin
                    m_top_next = m_top_reg;
                end
            endcase
            ro_next  = '0;
            co_next  = '0;
            ri_next  = '0;
            ci_next  = '0;
            cnt_next = '0;
        end
        else if (step)
        begin
            if (last)
            begin
                ro_next  = '0;
                co_next  = '0;
                ri_next  = '0;
                ci_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if ((co_reg == ro_reg) && (ci_reg >= ri_reg))
                begin
                    // end of a result row: start the next one
                    co_next = '0;
                    ci_next = '0;
                    if (ri_reg == n_top_reg)
                    begin
                        ri_next = '0;
                        ro_next = ro_reg + RW1'(1);
                    end
                    else
                    begin
                        ri_next = ri_reg + RW2'(1);
                    end
                end
                else if (ci_reg == n_top_reg)
                begin
                    ci_next = '0;
                    co_next = co_reg + RW1'(1);
                end
                else
                begin
                    ci_next = ci_reg + RW2'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_top_reg <= '0;
            n_top_reg <= '0;
            ro_reg    <= '0;
            co_reg    <= '0;
            ri_reg    <= '0;
            ci_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            m_top_reg <= m_top_next;
            n_top_reg <= n_top_next;
            ro_reg    <= ro_next;
            co_reg    <= co_next;
            ri_reg    <= ri_next;
            ci_reg    <= ci_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/core/phk_cmul.sv
// Exact complex multiply of two Q1.23 values, optionally conjugating the second.
module phk_cmul
    import phk_pkg::*;
(
    input  logic signed [PART_W-1:0] a_re,
    input  logic signed [PART_W-1:0] a_im,
    input  logic signed [PART_W-1:0] b_re,
    input  logic signed [PART_W-1:0] b_im,
    input  logic                     conj,
    output logic signed [PROD_W-1:0] prod_re,
    output logic signed [PROD_W-1:0] prod_im
);

    logic signed [2*PART_W-1:0] rr, ii, ri, ir;
    logic signed [PROD_W-1:0]   rr_x, ii_x, ri_x, ir_x;

    assign rr = a_re * b_re;
    assign ii = a_im * b_im;
    assign ri = a_re * b_im;
    assign ir = a_im * b_re;

    assign rr_x = PROD_W'(rr);
    assign ii_x = PROD_W'(ii);
    assign ri_x = PROD_W'(ri);
    assign ir_x = PROD_W'(ir);

    // fold the conjugate into the signs so the negated part never overflows
    assign prod_re = conj ? (rr_x + ii_x) : (rr_x - ii_x);
    assign prod_im = conj ? (ir_x - ri_x) : (ri_x + ir_x);

endmodule

>>> rtl/core/packed_hermitian_kronecker_product_unit.sv
// Top level of the packed Hermitian Kronecker product unit.
//
//  channel  | direction | handshake              | content
//  ---------+-----------+------------------------+------------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | tuser: opcode; tdata: load index, re, im
//  m_axis   | out       | m_axis_tvalid/tready   | tdata: prod re, prod im, index; tlast
//  cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data (m_size, n_size)
//
// One item per cycle sustained while the result side does not stall; an emit item is held in the input
// register from the accepting edge, and its result enters the result register once that is free or drained.
// The four 24x24 products and their sums between the two registers set the cycle time.
// Reset clears the order registers to order 1 and the position counters; the matrix stores
// hold whatever was last loaded and are not cleared.
// A stalled result holds the result register; the input register takes one more item.
module packed_hermitian_kronecker_product_unit
    import phk_pkg::*;
#(
    parameter int MAX_M = 4,
    parameter int MAX_N = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // load_index[3:0], elem_re[27:4], elem_im[51:28]
    input  logic [IN_USER_W-1:0]   s_axis_tuser,   // opcode[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // prod_re[48:0], prod_im[97:49], out_index[105:98]
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ORDER_W-1:0]     cfg_data
);

    localparam int DEPTH1 = MAX_M * (MAX_M + 1) / 2;
    localparam int DEPTH2 = MAX_N * (MAX_N + 1) / 2;
    localparam int AW1 = (DEPTH1 > 1) ? $clog2(DEPTH1) : 1;
    localparam int AW2 = (DEPTH2 > 1) ? $clog2(DEPTH2) : 1;
    localparam int PAD_W = OUT_DATA_W - 2 * PROD_W - OUT_INDEX_W;

    logic                    in_valid_reg, in_valid_next;
    logic [IN_USER_W-1:0]    in_op_reg;
    logic [LOAD_INDEX_W-1:0] in_idx_reg;
    logic [ENTRY_W-1:0]      in_entry_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [PROD_W-1:0]       out_re_reg, out_im_reg;
    logic [OUT_INDEX_W-1:0]  out_index_reg;
    logic                    out_last_reg;

    logic                    in_fire;
    logic                    s1_fire;
    logic                    emit_fire;
    logic                    cfg_fire;
    logic                    is_emit;
    logic                    is_load1;
    logic                    is_load2;
    logic [AW1-1:0]          a1;
    logic [AW2-1:0]          a2;
    seq_status_t             status;
    logic [ENTRY_W-1:0]      rd1, rd2;
    logic signed [PROD_W-1:0] prod_re, prod_im;

    always_comb
    begin
        is_emit  = 1'b0;
        is_load1 = 1'b0;
        is_load2 = 1'b0;
        case (opcode_t'(in_op_reg))
            OP_LOAD_FIRST:  is_load1 = 1'b1;
            OP_LOAD_SECOND: is_load2 = 1'b1;
            OP_EMIT:        is_emit  = 1'b1;
            default:        is_emit  = 1'b0;
        endcase
    end

    // the staged item moves on whenever the result register is free or being drained
    assign s1_fire   = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign emit_fire = s1_fire && is_emit;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign s_axis_tready = !in_valid_reg || s1_fire;
    assign cfg_ready     = 1'b1;

    phk_seq #(
        .MAX_M (MAX_M),
        .MAX_N (MAX_N)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (emit_fire),
        .a1        (a1),
        .a2        (a2),
        .status    (status)
    );

    phk_store #(
        .DEPTH (DEPTH1)
    ) u_first (
        .clk      (clk),
        .wr_en    (s1_fire && is_load1),
        .wr_index (in_idx_reg),
        .wr_data  (in_entry_reg),
        .rd_addr  (a1),
        .rd_data  (rd1)
    );

    phk_store #(
        .DEPTH (DEPTH2)
    ) u_second (
        .clk      (clk),
        .wr_en    (s1_fire && is_load2),
        .wr_index (in_idx_reg),
        .wr_data  (in_entry_reg),
        .rd_addr  (a2),
        .rd_data  (rd2)
    );

    phk_cmul u_cmul (
        .a_re    ($signed(rd1[PART_W-1:0])),
        .a_im    ($signed(rd1[ENTRY_W-1:PART_W])),
        .b_re    ($signed(rd2[PART_W-1:0])),
        .b_im    ($signed(rd2[ENTRY_W-1:PART_W])),
        .conj    (status.conj),
        .prod_re (prod_re),
        .prod_im (prod_im)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (s1_fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg    <= s_axis_tuser;
            in_idx_reg   <= s_axis_tdata[LOAD_INDEX_W-1:0];
            in_entry_reg <= {s_axis_tdata[LOAD_INDEX_W+2*PART_W-1:LOAD_INDEX_W+PART_W],
                             s_axis_tdata[LOAD_INDEX_W+PART_W-1:LOAD_INDEX_W]};
        end
        if (emit_fire)
        begin
            out_re_reg    <= prod_re;
            out_im_reg    <= prod_im;
            out_index_reg <= status.index;
            out_last_reg  <= status.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_index_reg, out_im_reg, out_re_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_no_advance_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s1_fire)
        else $error("staged item advanced into a stalled result register");

    a_ready_low_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input refused while the pipeline has room");

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((emit_fire && status.last) || cfg_fire) |=> (status.index == '0))
        else $error("sequence did not return to element zero");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !status.last && !cfg_fire)
            |=> (status.index == OUT_INDEX_W'($past(status.index) + OUT_INDEX_W'(1))))
        else $error("packed index did not advance by one");
`endif

endmodule

>>> test/phk_checker.sv
// Checker for the packed Hermitian Kronecker product unit: predicts every emitted element and compares.
module phk_checker
    import phk_pkg::*;
#(
    parameter int MAX_M = 4,
    parameter int MAX_N = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [IN_USER_W-1:0]   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ORDER_W-1:0]     cfg_data,
    output int                     fail_count,
    output int                     elems_outstanding
);

    localparam int FIRST_DEPTH  = MAX_M * (MAX_M + 1) / 2;
    localparam int SECOND_DEPTH = MAX_N * (MAX_N + 1) / 2;

    typedef struct packed {
        logic signed [PROD_W-1:0] re;
        logic signed [PROD_W-1:0] im;
        logic [OUT_INDEX_W-1:0]   index;
        logic                     last;
    } elem_t;

    logic signed [PART_W-1:0] first_re  [FIRST_DEPTH];
    logic signed [PART_W-1:0] first_im  [FIRST_DEPTH];
    logic signed [PART_W-1:0] second_re [SECOND_DEPTH];
    logic signed [PART_W-1:0] second_im [SECOND_DEPTH];
    logic [ORDER_W-1:0]       m_order;
    logic [ORDER_W-1:0]       n_order;
    logic [1:0]               row_outer;
    logic [1:0]               row_inner;
    logic [1:0]               col_outer;
    logic [1:0]               col_inner;
    logic [OUT_INDEX_W-1:0]   emit_pos;
    elem_t                    expected_elems [$];

    // Zero acts as order one, anything above the maximum as the maximum.
    function automatic int unsigned eff_order(input logic [ORDER_W-1:0] v, input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic int unsigned tri_base(input int unsigned r);
        return r * (r + 1) / 2;
    endfunction

    task automatic restart_sequence();
        row_outer = '0;
        row_inner = '0;
        col_outer = '0;
        col_inner = '0;
        emit_pos  = '0;
    endtask

    task automatic predict_element();
        int unsigned m;
        int unsigned n;
        int unsigned mn;
        int unsigned total;
        int unsigned a1;
        int unsigned a2;
        longint      ar;
        longint      ai;
        longint      br;
        longint      bi;
        longint      pr;
        longint      pi;
        elem_t       e;
        m     = eff_order(m_order, MAX_M);
        n     = eff_order(n_order, MAX_N);
        mn    = m * n;
        total = mn * (mn + 1) / 2;
        a1    = tri_base(row_outer) + col_outer;
        ar    = longint'(first_re[a1]);
        ai    = longint'(first_im[a1]);
        if (col_inner <= row_inner)
        begin
            a2 = tri_base(row_inner) + col_inner;
            br = longint'(second_re[a2]);
            bi = longint'(second_im[a2]);
        end
        else
        begin
            // Upper triangle of the second factor: take the conjugate of the mirrored entry.
            a2 = tri_base(col_inner) + row_inner;
            br = longint'(second_re[a2]);
            bi = -longint'(second_im[a2]);
        end
        pr      = ar * br - ai * bi;
        pi      = ar * bi + ai * br;
        e.re    = pr[PROD_W-1:0];
        e.im    = pi[PROD_W-1:0];
        e.index = emit_pos;
        e.last  = (int'(emit_pos) + 1 >= total);
        expected_elems.push_back(e);
        if (e.last)
            restart_sequence();
        else
        begin
            emit_pos++;
            if (col_outer == row_outer && col_inner >= row_inner)
            begin
                col_outer = '0;
                col_inner = '0;
                if (int'(row_inner) + 1 >= n)
                begin
                    row_inner = '0;
                    row_outer++;
                end
                else
                    row_inner++;
            end
            else
            begin
                if (int'(col_inner) + 1 >= n)
                begin
                    col_inner = '0;
                    col_outer++;
                end
                else
                    col_inner++;
            end
        end
    endtask

    task automatic check_element();
        elem_t want;
        elem_t got;
        got.re    = m_axis_tdata[PROD_W-1:0];
        got.im    = m_axis_tdata[2*PROD_W-1:PROD_W];
        got.index = m_axis_tdata[2*PROD_W+OUT_INDEX_W-1:2*PROD_W];
        got.last  = m_axis_tlast;
        if (expected_elems.size() == 0)
        begin
            fail_count++;
            $display("%0t: unexpected element: actual re=%0d im=%0d index=%0d last=%0b",
                     $time, got.re, got.im, got.index, got.last);
            return;
        end
        want = expected_elems.pop_front();
        if (got.re !== want.re || got.im !== want.im || got.index !== want.index ||
            got.last !== want.last)
        begin
            fail_count++;
            $display("%0t: element mismatch: expected re=%0d im=%0d index=%0d last=%0b",
                     $time, want.re, want.im, want.index, want.last);
            $display("%0t:                   actual   re=%0d im=%0d index=%0d last=%0b",
                     $time, got.re, got.im, got.index, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [LOAD_INDEX_W-1:0] idx;
        logic [PART_W-1:0]       part_re;
        logic [PART_W-1:0]       part_im;
        if (!rst_n)
        begin
            // Stores are left alone: they are undefined until loaded.
            m_order = 3'd1;
            n_order = 3'd1;
            restart_sequence();
            expected_elems.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_element();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_M_SIZE: m_order = cfg_data;
                    CFG_N_SIZE: n_order = cfg_data;
                    default: ;
                endcase
                restart_sequence();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                idx     = s_axis_tdata[LOAD_INDEX_W-1:0];
                part_re = s_axis_tdata[LOAD_INDEX_W+PART_W-1:LOAD_INDEX_W];
                part_im = s_axis_tdata[LOAD_INDEX_W+2*PART_W-1:LOAD_INDEX_W+PART_W];
                case (opcode_t'(s_axis_tuser))
                    OP_LOAD_FIRST:
                        if (idx < FIRST_DEPTH)
                        begin
                            first_re[idx] = part_re;
                            first_im[idx] = part_im;
                        end
                    OP_LOAD_SECOND:
                        if (idx < SECOND_DEPTH)
                        begin
                            second_re[idx] = part_re;
                            second_im[idx] = part_im;
                        end
                    OP_EMIT:
                        predict_element();
                    default: ;
                endcase
            end
        end
        elems_outstanding = expected_elems.size();
    end

endmodule

>>> test/packed_hermitian_kronecker_product_unit_tb.sv
// Testbench top for the packed Hermitian Kronecker product unit: stimulus, flow control and verdict.
module packed_hermitian_kronecker_product_unit_tb;
    import phk_pkg::*;

    localparam logic [IN_USER_W-1:0] OP_RESERVED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [IN_USER_W-1:0]   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ORDER_W-1:0]     cfg_data;
    int                     fail_count;
    int                     elems_outstanding;
    bit                     hold_request = 1'b0;
    bit                     gaps_on;
    int                     burst_left;

    packed_hermitian_kronecker_product_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    phk_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_axis_tvalid     (s_axis_tvalid),
        .s_axis_tready     (s_axis_tready),
        .s_axis_tdata      (s_axis_tdata),
        .s_axis_tuser      (s_axis_tuser),
        .m_axis_tvalid     (m_axis_tvalid),
        .m_axis_tready     (m_axis_tready),
        .m_axis_tdata      (m_axis_tdata),
        .m_axis_tlast      (m_axis_tlast),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .elems_outstanding (elems_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("packed_hermitian_kronecker_product_unit_tb failed");
        $finish;
    end

    // Result side: stall pattern that changes mode now and then, plus one long hold-off on request.
    initial
    begin : receiver
        int   mode;
        int   mode_left;
        int   hold_left;
        logic ready_next;
        logic toggle;
        m_axis_tready = 1'b0;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        toggle        = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = 400;
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 4);
                mode_left = $urandom_range(30, 300);
            end
            else
                mode_left--;
            toggle = ~toggle;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                case (mode)
                    0: ready_next = 1'b1;
                    1: ready_next = $urandom_range(0, 1);
                    2: ready_next = ($urandom_range(0, 3) != 0);
                    3: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = toggle;
                endcase
            m_axis_tready <= ready_next;
        end
    end

    function automatic logic [PART_W-1:0] pick_part();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return PART_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic [IN_USER_W-1:0] op, input logic [LOAD_INDEX_W-1:0] idx,
                             input logic [PART_W-1:0] re, input logic [PART_W-1:0] im);
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            else
                burst_left--;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {{(IN_DATA_W-LOAD_INDEX_W-2*PART_W){1'b0}}, im, re, idx};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_order(input cfg_reg_t which, input logic [ORDER_W-1:0] value);
        @(negedge clk);
        cfg_index <= which;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every element, then let any load still in flight settle.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (elems_outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [ORDER_W-1:0] m, input logic [ORDER_W-1:0] n,
                             input int count, input bit idle, input bit squeeze);
        int done;
        int r;
        write_order(CFG_M_SIZE, m);
        write_order(CFG_N_SIZE, n);
        gaps_on    = idle;
        burst_left = 0;
        done       = 0;
        while (done < count)
        begin
            if (squeeze && done == 40)
                hold_request = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                send_item(OP_EMIT, LOAD_INDEX_W'($urandom), pick_part(), pick_part());
                done++;
            end
            else if (r < 90)
            begin
                send_item((r < 72) ? OP_LOAD_FIRST : OP_LOAD_SECOND,
                          LOAD_INDEX_W'($urandom_range(0, 9)), pick_part(), pick_part());
                done++;
            end
            else if (r < 95)
                send_item(OP_RESERVED, LOAD_INDEX_W'($urandom), pick_part(), pick_part());
            else
                send_item(r[0] ? OP_LOAD_FIRST : OP_LOAD_SECOND,
                          LOAD_INDEX_W'($urandom_range(10, 15)), pick_part(), pick_part());
        end
        drain();
    endtask

    initial
    begin : stimulus
        int phase_m [9];
        int phase_n [9];
        int phase_k [9];
        phase_m       = '{4, 0, 7, 2, 3, 1, 4, 5, 6};
        phase_n       = '{4, 0, 7, 3, 2, 4, 1, 6, 0};
        phase_k       = '{300, 60, 200, 150, 150, 100, 100, 150, 60};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_LOAD_FIRST;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_M_SIZE;
        cfg_data      = '0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Directed: zero orders act as one, extremes of the parts, ignored items.
        write_order(CFG_M_SIZE, 3'd0);
        write_order(CFG_N_SIZE, 3'd0);
        send_item(OP_LOAD_FIRST, 4'd0, 24'h7FFFFF, 24'h800000);
        send_item(OP_LOAD_SECOND, 4'd0, 24'h800000, 24'h800000);
        send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        send_item(OP_EMIT, 4'd15, 24'hFFFFFF, 24'hFFFFFF);
        send_item(OP_LOAD_FIRST, 4'd15, 24'h123456, 24'h654321);
        send_item(OP_LOAD_SECOND, 4'd10, 24'h000000, 24'h000000);
        send_item(OP_RESERVED, 4'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        send_item(OP_LOAD_FIRST, 4'd0, 24'h800000, 24'h800000);
        send_item(OP_LOAD_SECOND, 4'd0, 24'h800000, 24'h7FFFFF);
        send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        send_item(OP_LOAD_FIRST, 4'd0, 24'h7FFFFF, 24'h7FFFFF);
        send_item(OP_LOAD_SECOND, 4'd0, 24'h7FFFFF, 24'h800000);
        send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        send_item(OP_LOAD_FIRST, 4'd0, 24'h000000, 24'hFFFFFF);
        send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        drain();
        write_order(CFG_M_SIZE, 3'd1);
        write_order(CFG_N_SIZE, 3'd2);
        send_item(OP_LOAD_SECOND, 4'd1, 24'h800000, 24'h7FFFFF);
        send_item(OP_LOAD_SECOND, 4'd2, 24'h7FFFFF, 24'h000000);
        repeat (4) send_item(OP_EMIT, 4'd0, 24'h000000, 24'h000000);
        drain();

        // Load every entry of both stores so that any order may be emitted from here on.
        for (int k = 0; k < 10; k++)
        begin
            send_item(OP_LOAD_FIRST, LOAD_INDEX_W'(k), pick_part(), pick_part());
            send_item(OP_LOAD_SECOND, LOAD_INDEX_W'(k), pick_part(), pick_part());
        end
        drain();

        for (int p = 0; p < 9; p++)
            run_phase(ORDER_W'(phase_m[p]), ORDER_W'(phase_n[p]), phase_k[p], p != 2 && p != 6,
                      p == 0);
        repeat (3)
            run_phase(ORDER_W'($urandom_range(0, 7)), ORDER_W'($urandom_range(0, 7)), 30,
                      1'b1, 1'b0);

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (elems_outstanding != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("packed_hermitian_kronecker_product_unit_tb passed");
        else
            $display("packed_hermitian_kronecker_product_unit_tb failed");
        $finish;
    end

endmodule
